// ===== src/mhpq_pkg.sv =====
// Shared constants, types and state codes for the max-heap priority queue.
package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 31;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int LW       = IDX_W + 1;
	localparam int IN_DW    = ((KEY_W + 7) / 8) * 8;
	localparam int OUT_W    = 2 * KEY_W + 3 + CNT_W;
	localparam int OUT_DW   = ((OUT_W + 7) / 8) * 8;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_CMP,
		ST_DN_LAST,
		ST_DN,
		ST_DN_CMP,
		ST_DONE
	} state_t;

endpackage

// ===== src/max_heap_priority_queue_core.sv =====
// Binary max-heap priority queue: key store, sift sequencer and result register.
//
//  channel | dir | contents
//  s_*     | in  | tuser: func; tdata: key (bits 30:0)
//  m_*     | out | tdata: popped_key, empty_error, full_error, top_key, top_valid, fill_count
//
// Acceptance to result: an insert climbs through ST_UP and ST_UP_CMP per level, a pop reads
// the last key in ST_DN_LAST and descends through ST_DN and ST_DN_CMP per level; full insert,
// empty pop and pop of the last key go straight to ST_DONE. The sequencer returns to idle
// after ST_DONE; each level is a registered store read followed by the single compare path.
// Input is taken only in idle; a result waiting on m_tready holds the sequencer in its
// final state but the next transaction is still taken while the result register is full.
// Reset clears the count; the store needs no clearing pass.
module max_heap_priority_queue_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mhpq_pkg::IN_DW-1:0]  s_tdata,  // key[30:0], zero pad
	input  logic                        s_tuser,  // func
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mhpq_pkg::OUT_DW-1:0] m_tdata   // popped_key, empty_error, full_error,
	                                              // top_key, top_valid, fill_count
);
	import mhpq_pkg::*;

	state_t state_q, state_d;
	cnt_t   cnt_q, cnt_d;
	idx_t   pos_q, pos_d;
	key_t   cur_q, cur_d;
	key_t   top_q, top_d;
	key_t   popped_q, popped_d;
	logic   eerr_q, eerr_d;
	logic   ferr_q, ferr_d;
	logic   m_valid_q, m_valid_d;
	logic [OUT_DW-1:0] m_data_q, m_data_d;

	key_t   mem [CAPACITY];
	key_t   rd_a_q, rd_b_q;
	idx_t   rd_addr_a, rd_addr_b, wr_addr;
	key_t   wr_data;
	logic   we;

	logic [LW-1:0] lft, rgt;
	logic          rgt_ok;
	logic          pick_r;
	key_t          big_val;
	idx_t          big_idx;
	logic          out_free;
	logic          accept;

	assign lft      = {pos_q, 1'b1};
	assign rgt      = lft + LW'(1);
	assign rgt_ok   = rgt < LW'(cnt_q);
	assign pick_r   = rgt_ok && (rd_b_q > rd_a_q);
	assign big_val  = pick_r ? rd_b_q : rd_a_q;
	assign big_idx  = pick_r ? rgt[IDX_W-1:0] : lft[IDX_W-1:0];
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		cur_q    <= cur_d;
		top_q    <= top_d;
		popped_q <= popped_d;
		eerr_q   <= eerr_d;
		ferr_q   <= ferr_d;
		m_data_q <= m_data_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		cur_d     = cur_q;
		top_d     = top_q;
		popped_d  = popped_q;
		eerr_d    = eerr_q;
		ferr_d    = ferr_q;
		m_valid_d = m_valid_q && !m_tready;
		m_data_d  = m_data_q;
		rd_addr_a = lft[IDX_W-1:0];
		rd_addr_b = rgt[IDX_W-1:0];
		wr_addr   = pos_q;
		wr_data   = cur_q;
		we        = 1'b0;

		case (state_q)
			ST_IDLE: begin
				rd_addr_a = IDX_W'(cnt_q - cnt_t'(1));
				if (accept) begin
					popped_d = '0;
					eerr_d   = 1'b0;
					ferr_d   = 1'b0;
					if (s_tuser == FUNC_INSERT) begin
						if (cnt_q == cnt_t'(CAPACITY)) begin
							ferr_d  = 1'b1;
							state_d = ST_DONE;
						end else begin
							cur_d   = s_tdata[KEY_W-1:0];
							pos_d   = IDX_W'(cnt_q);
							cnt_d   = cnt_q + cnt_t'(1);
							state_d = ST_UP;
						end
					end else begin
						if (cnt_q == '0) begin
							eerr_d  = 1'b1;
							state_d = ST_DONE;
						end else begin
							popped_d = top_q;
							cnt_d    = cnt_q - cnt_t'(1);
							state_d  = (cnt_q == cnt_t'(1)) ? ST_DONE : ST_DN_LAST;
						end
					end
				end
			end
			ST_UP: begin
				rd_addr_a = (pos_q - idx_t'(1)) >> 1;
				if (pos_q == '0) begin
					we      = 1'b1;
					top_d   = cur_q;
					state_d = ST_DONE;
				end else begin
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				we = 1'b1;
				if (rd_a_q < cur_q) begin
					wr_data = rd_a_q;
					pos_d   = (pos_q - idx_t'(1)) >> 1;
					state_d = ST_UP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DN_LAST: begin
				cur_d   = rd_a_q;
				pos_d   = '0;
				state_d = ST_DN;
			end
			ST_DN: begin
				if (lft >= LW'(cnt_q)) begin
					we = 1'b1;
					if (pos_q == '0)
						top_d = cur_q;
					state_d = ST_DONE;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				we = 1'b1;
				if (big_val > cur_q) begin
					wr_data = big_val;
					if (pos_q == '0)
						top_d = big_val;
					pos_d   = big_idx;
					state_d = ST_DN;
				end else begin
					if (pos_q == '0)
						top_d = cur_q;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_valid_d = 1'b1;
					m_data_d  = OUT_DW'({cnt_q, (cnt_q != '0),
						((cnt_q != '0) ? top_q : key_t'(0)),
						ferr_q, eerr_q, popped_q});
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/mhpq_checker.sv =====
// Port-level checks for the max-heap priority queue, bound to the top level.
module mhpq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [mhpq_pkg::OUT_DW-1:0] m_tdata
);
	import mhpq_pkg::*;

	logic [KEY_W-1:0] popped_key;
	logic             empty_error;
	logic             full_error;
	logic             top_valid;
	logic [CNT_W-1:0] fill_count;

	assign popped_key  = m_tdata[KEY_W-1:0];
	assign empty_error = m_tdata[KEY_W];
	assign full_error  = m_tdata[KEY_W+1];
	assign top_valid   = m_tdata[2*KEY_W+2];
	assign fill_count  = m_tdata[2*KEY_W+3+CNT_W-1:2*KEY_W+3];

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready right after a transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> top_valid == (fill_count != '0))
		else $error("top_valid disagrees with fill_count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && empty_error |-> popped_key == '0 && fill_count == '0 && !full_error)
		else $error("bad empty pop transaction");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && full_error |-> fill_count == CNT_W'(CAPACITY))
		else $error("full flag with room left");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/max_heap_priority_queue_core_tb.sv =====
// Self-checking testbench for the max-heap priority queue: random stream traffic, scoreboard.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;
	import mhpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 500;

	localparam key_t KEY_MAX = {KEY_W{1'b1}};

	// popped_key in the low bits, fill_count at the top
	typedef struct packed {
		cnt_t fill_count;
		logic top_valid;
		key_t top_key;
		logic full_error;
		logic empty_error;
		key_t popped_key;
	} heap_report_t;

	class heap_scoreboard;
		key_t         slots[CAPACITY];
		int unsigned  held;
		heap_report_t awaited_reports[$];
		int unsigned  errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		// apply one accepted operation to the shadow heap, queue the report it yields
		function void note_item(logic op, key_t key);
			heap_report_t rep;
			int unsigned  pos;
			int unsigned  up;
			int unsigned  lft;
			int unsigned  big;
			key_t         tmp;
			rep = '0;
			if (op == FUNC_INSERT) begin
				if (held >= CAPACITY) begin
					rep.full_error = 1'b1;
				end else begin
					slots[held] = key;
					pos = held;
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (slots[pos] <= slots[up])
							break;
						tmp = slots[up];
						slots[up] = slots[pos];
						slots[pos] = tmp;
						pos = up;
					end
					held++;
				end
			end else begin
				if (held == 0) begin
					rep.empty_error = 1'b1;
				end else begin
					rep.popped_key = slots[0];
					held--;
					slots[0] = slots[held];
					pos = 0;
					forever begin
						lft = 2 * pos + 1;
						if (lft >= held)
							break;
						big = lft;
						if (lft + 1 < held && slots[lft + 1] > slots[lft])
							big = lft + 1;
						if (slots[big] <= slots[pos])
							break;
						tmp = slots[pos];
						slots[pos] = slots[big];
						slots[big] = tmp;
						pos = big;
					end
				end
			end
			rep.top_valid  = (held > 0);
			rep.top_key    = (held > 0) ? slots[0] : '0;
			rep.fill_count = cnt_t'(held);
			awaited_reports.push_back(rep);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DW-1:0] data);
			heap_report_t got;
			heap_report_t want;
			got = heap_report_t'(data);
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected result transaction, actual %0h", $time, data);
				errors++;
				return;
			end
			want = awaited_reports.pop_front();
			compare_field("popped_key", 32'(want.popped_key), 32'(got.popped_key));
			compare_field("empty_error", 32'(want.empty_error), 32'(got.empty_error));
			compare_field("full_error", 32'(want.full_error), 32'(got.full_error));
			compare_field("top_key", 32'(want.top_key), 32'(got.top_key));
			compare_field("top_valid", 32'(want.top_valid), 32'(got.top_valid));
			compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
		endfunction

		function int unsigned outstanding();
			return awaited_reports.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_DW-1:0] m_tdata;

	heap_scoreboard sb;
	bit             no_gaps;
	int unsigned    idle_cycles;

	max_heap_priority_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(s_tuser, s_tdata[KEY_W-1:0]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// ends the run if no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic key_t draw_key(int mode);
		case (mode)
			1: return key_t'($urandom_range(0, 7));
			2: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return KEY_MAX;
					2: return KEY_MAX - 1;
					3: return key_t'(1);
					default: return key_t'($urandom());
				endcase
			end
			default: return key_t'($urandom());
		endcase
	endfunction

	task automatic send_item(input logic op, input key_t key);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_DW-KEY_W){1'b0}}, key};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic run_phase(int unsigned count, int unsigned insert_pct, int key_mode);
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(1, 100) <= insert_pct)
				send_item(FUNC_INSERT, draw_key(key_mode));
			else
				send_item(FUNC_POP, key_t'($urandom()));
		end
	endtask

	// result side: random stalls per transaction
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int unsigned sent;
		int unsigned len;
		sb          = new();
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = FUNC_INSERT;
		no_gaps     = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, equal keys, alternating bit patterns, drain past empty
		send_item(FUNC_POP, KEY_MAX);
		send_item(FUNC_INSERT, '0);
		send_item(FUNC_POP, key_t'(31'h2AAA_AAAA));
		send_item(FUNC_INSERT, KEY_MAX);
		send_item(FUNC_INSERT, '0);
		send_item(FUNC_INSERT, KEY_MAX);
		send_item(FUNC_INSERT, key_t'(5));
		send_item(FUNC_INSERT, key_t'(5));
		send_item(FUNC_INSERT, key_t'(1));
		send_item(FUNC_INSERT, key_t'(31'h3FFF_FFFF));
		send_item(FUNC_INSERT, key_t'(31'h4000_0000));
		send_item(FUNC_INSERT, key_t'(31'h2AAA_AAAA));
		send_item(FUNC_INSERT, key_t'(31'h5555_5555));
		repeat (11) send_item(FUNC_POP, key_t'($urandom()));

		// fill past capacity, then drain past empty
		run_phase(80, 95, 0);
		no_gaps = 1'b1;
		run_phase(80, 5, 1);
		no_gaps = 1'b0;
		sent = 184;
		while (sent < RANDOM_ITEMS) begin
			len = $urandom_range(20, 90);
			if (len > RANDOM_ITEMS - sent)
				len = RANDOM_ITEMS - sent;
			no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: run_phase(len, 90, $urandom_range(0, 2));
				1: run_phase(len, 10, $urandom_range(0, 2));
				default: run_phase(len, 50, $urandom_range(0, 2));
			endcase
			sent += len;
		end
		no_gaps = 1'b0;
		s_tvalid <= 1'b0;

		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/mhpq_pkg.sv
src/max_heap_priority_queue_core.sv
src/mhpq_checker.sv
tb/max_heap_priority_queue_core_tb.sv
